[hdl/bfm_pkg.sv]
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared constants, controller step codes and command/status types for the
// Bloom filter with MurmurHash3 key hashing.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int unsigned MaxHashes     = 20;
  localparam int unsigned MaxFilterBits = 1048576;
  localparam int unsigned RowBits       = 32;
  localparam int unsigned NumRows       = MaxFilterBits / RowBits;
  localparam int unsigned RowAw         = $clog2(NumRows);
  localparam int unsigned BitAw         = $clog2(RowBits);
  localparam int unsigned PosW          = RowAw + BitAw;

  localparam logic [31:0] MmC1 = 32'hcc9e2d51;
  localparam logic [31:0] MmC2 = 32'h1b873593;
  localparam logic [31:0] MmE  = 32'he6546b64;
  localparam logic [31:0] MmF1 = 32'h85ebca6b;
  localparam logic [31:0] MmF2 = 32'hc2b2ae35;
  localparam logic [31:0] MmLen = 32'd20;

  localparam logic CfgNumHashes  = 1'b0;
  localparam logic CfgFilterBits = 1'b1;

  localparam logic OpInsert = 1'b0;
  localparam logic OpCheck  = 1'b1;

  localparam logic [3:0] StepNop   = 4'd0;
  localparam logic [3:0] StepClear = 4'd1;
  localparam logic [3:0] StepLoad  = 4'd2;
  localparam logic [3:0] StepK1    = 4'd3;
  localparam logic [3:0] StepK2    = 4'd4;
  localparam logic [3:0] StepRound = 4'd5;
  localparam logic [3:0] StepF0    = 4'd6;
  localparam logic [3:0] StepF1    = 4'd7;
  localparam logic [3:0] StepF2    = 4'd8;
  localparam logic [3:0] StepMod   = 4'd9;
  localparam logic [3:0] StepRead  = 4'd10;
  localparam logic [3:0] StepBit   = 4'd11;
  localparam logic [3:0] StepDone  = 4'd12;

  typedef struct packed {
    logic [3:0]       step;
    logic [2:0]       blk;
    logic [4:0]       seed;
    logic [RowAw-1:0] clr_addr;
  } bfm_cmd_t;

  typedef struct packed {
    logic [4:0] nh;
    logic       op;
    logic       bit_set;
    logic       out_busy;
  } bfm_stat_t;

endpackage

[hdl/bfm_ctrl.sv]
// ----------------------------------------------------------------------------
// bfm_ctrl
// Sequencer: store clearing, key mixing, per-seed hash, modulo and bit access.
// ----------------------------------------------------------------------------
module bfm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bfm_pkg::bfm_stat_t stat_i,
  output bfm_pkg::bfm_cmd_t  cmd_o
);
  import bfm_pkg::*;

  localparam logic [3:0] StClr  = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StK1   = 4'd2;
  localparam logic [3:0] StK2   = 4'd3;
  localparam logic [3:0] StRnd  = 4'd4;
  localparam logic [3:0] StF0   = 4'd5;
  localparam logic [3:0] StF1   = 4'd6;
  localparam logic [3:0] StF2   = 4'd7;
  localparam logic [3:0] StMod  = 4'd8;
  localparam logic [3:0] StRd   = 4'd9;
  localparam logic [3:0] StBit  = 4'd10;
  localparam logic [3:0] StDone = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [2:0]       blk_q, blk_d;
  logic [4:0]       seed_q, seed_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [RowAw-1:0] clr_q, clr_d;
  logic             last_seed;

  assign last_seed = ({1'b0, seed_q} + 6'd1) == {1'b0, stat_i.nh};

  always_comb begin
    state_d = state_q;
    blk_d   = blk_q;
    seed_d  = seed_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    cmd_o.step     = StepNop;
    cmd_o.blk      = blk_q;
    cmd_o.seed     = seed_q;
    cmd_o.clr_addr = clr_q;
    case (state_q)
      StClr: begin
        cmd_o.step = StepClear;
        clr_d = clr_q + 1'b1;
        if (clr_q == {RowAw{1'b1}}) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.step = StepLoad;
          blk_d = 3'd0;
          state_d = StK1;
        end
      end
      StK1: begin
        cmd_o.step = StepK1;
        state_d = StK2;
      end
      StK2: begin
        cmd_o.step = StepK2;
        if (blk_q == 3'd4) begin
          blk_d = 3'd0;
          seed_d = 5'd0;
          state_d = (stat_i.nh == 5'd0) ? StDone : StRnd;
        end else begin
          blk_d = blk_q + 3'd1;
          state_d = StK1;
        end
      end
      StRnd: begin
        cmd_o.step = StepRound;
        if (blk_q == 3'd4) state_d = StF0;
        else blk_d = blk_q + 3'd1;
      end
      StF0: begin
        cmd_o.step = StepF0;
        state_d = StF1;
      end
      StF1: begin
        cmd_o.step = StepF1;
        state_d = StF2;
      end
      StF2: begin
        cmd_o.step = StepF2;
        cnt_d = 4'd0;
        state_d = StMod;
      end
      StMod: begin
        cmd_o.step = StepMod;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) state_d = StRd;
      end
      StRd: begin
        cmd_o.step = StepRead;
        state_d = StBit;
      end
      StBit: begin
        cmd_o.step = StepBit;
        if ((stat_i.op == OpCheck && !stat_i.bit_set) || last_seed) begin
          state_d = StDone;
        end else begin
          seed_d = seed_q + 5'd1;
          blk_d = 3'd0;
          state_d = StRnd;
        end
      end
      StDone: begin
        if (!stat_i.out_busy) begin
          cmd_o.step = StepDone;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      blk_q   <= 3'd0;
      seed_q  <= 5'd0;
      cnt_q   <= 4'd0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
      seed_q  <= seed_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

  assign in_stall_o = state_q != StIdle;

endmodule

[hdl/bfm_dp.sv]
// ----------------------------------------------------------------------------
// bfm_dp
// Datapath: config registers, shared multiplier, hash rounds, radix-4 modulo,
// filter bit store and output register.
// ----------------------------------------------------------------------------
module bfm_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfm_pkg::bfm_cmd_t cmd_i,
  output bfm_pkg::bfm_stat_t stat_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [20:0]       cfg_data_i,
  input  logic              operation_i,
  input  logic [31:0]       key_word0_i,
  input  logic [31:0]       key_word1_i,
  input  logic [31:0]       key_word2_i,
  input  logic [31:0]       key_word3_i,
  input  logic [31:0]       key_word4_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              maybe_present_o,
  output logic [31:0]       inserted_total_o
);
  import bfm_pkg::*;

  localparam logic [20:0] FbMax = 21'(MaxFilterBits);

  logic [4:0]  hash_cfg_q;
  logic [20:0] filter_bits_q;
  logic        op_q;
  logic [4:0]  nh_q;
  logic [20:0] fb_q;
  logic [31:0] w_q [5];
  logic [31:0] k_q [5];
  logic [31:0] p_q, h_q, dvd_q;
  logic [PosW-1:0] rem_q;
  logic        present_q;
  logic [31:0] cnt_q, cnt_nx;
  logic        out_valid_q, mp_q;
  logic [31:0] total_q;
  logic [31:0] rd_q;
  logic [31:0] mem [NumRows];

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] h_in, hx, hr, f0t;
  logic [PosW:0] r1, r2;
  logic [PosW-1:0] r1m;
  logic        mem_we;
  logic [RowAw-1:0] mem_wa;
  logic [31:0] mem_wd;

  always_comb begin
    mul_a = w_q[cmd_i.blk];
    mul_b = MmC1;
    f0t = h_q ^ MmLen;
    case (cmd_i.step)
      StepK2: begin
        mul_a = {p_q[16:0], p_q[31:17]};
        mul_b = MmC2;
      end
      StepF0: begin
        mul_a = f0t ^ (f0t >> 16);
        mul_b = MmF1;
      end
      StepF1: begin
        mul_a = p_q ^ (p_q >> 13);
        mul_b = MmF2;
      end
      default: begin
        mul_a = w_q[cmd_i.blk];
        mul_b = MmC1;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign h_in = (cmd_i.blk == 3'd0) ? {27'd0, cmd_i.seed} : h_q;
  assign hx   = h_in ^ k_q[cmd_i.blk];
  assign hr   = {hx[18:0], hx[31:19]};

  always_comb begin
    r1 = {rem_q, dvd_q[31]};
    if (r1 >= fb_q) r1 = r1 - fb_q;
    r1m = r1[PosW-1:0];
    r2 = {r1m, dvd_q[30]};
    if (r2 >= fb_q) r2 = r2 - fb_q;
  end

  assign cnt_nx = (op_q == OpInsert && cnt_q != 32'hffffffff) ? cnt_q + 32'd1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_cfg_q    <= 5'd14;
      filter_bits_q <= FbMax;
      cnt_q         <= 32'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgNumHashes) hash_cfg_q <= cfg_data_i[4:0];
        else filter_bits_q <= cfg_data_i;
      end
      if (cmd_i.step == StepDone) begin
        cnt_q <= cnt_nx;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      StepLoad: begin
        op_q <= operation_i;
        w_q[0] <= key_word0_i;
        w_q[1] <= key_word1_i;
        w_q[2] <= key_word2_i;
        w_q[3] <= key_word3_i;
        w_q[4] <= key_word4_i;
        nh_q <= (hash_cfg_q > 5'(MaxHashes)) ? 5'(MaxHashes) : hash_cfg_q;
        fb_q <= (filter_bits_q == 21'd0) ? 21'd1 :
                (filter_bits_q > FbMax) ? FbMax : filter_bits_q;
        present_q <= 1'b1;
      end
      StepK1:    p_q <= prod;
      StepK2:    k_q[cmd_i.blk] <= prod;
      StepRound: h_q <= (hr << 2) + hr + MmE;
      StepF0:    p_q <= prod;
      StepF1:    p_q <= prod;
      StepF2: begin
        dvd_q <= p_q ^ (p_q >> 16);
        rem_q <= '0;
      end
      StepMod: begin
        rem_q <= r2[PosW-1:0];
        dvd_q <= {dvd_q[29:0], 2'b00};
      end
      StepBit: begin
        if (op_q == OpCheck && !stat_o.bit_set) present_q <= 1'b0;
      end
      StepDone: begin
        mp_q <= (op_q == OpCheck) && present_q;
        total_q <= cnt_nx;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = rem_q[PosW-1:BitAw];
    mem_wd = rd_q | (32'd1 << rem_q[BitAw-1:0]);
    if (cmd_i.step == StepClear) begin
      mem_we = 1'b1;
      mem_wa = cmd_i.clr_addr;
      mem_wd = 32'd0;
    end else if (cmd_i.step == StepBit && op_q == OpInsert) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.step == StepRead) rd_q <= mem[rem_q[PosW-1:BitAw]];
  end

  assign stat_o.nh       = nh_q;
  assign stat_o.op       = op_q;
  assign stat_o.bit_set  = rd_q[rem_q[BitAw-1:0]];
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign maybe_present_o  = mp_q;
  assign inserted_total_o = total_q;

endmodule

[hdl/bloom_filter_murmur3_key160.sv]
// Each transaction mixes the key, then per hash runs 5 rounds, 3 finalizer steps,
//   16 radix-4 modulo steps, a read and a bit update, then registers the result.
// One transaction at a time: a new key is taken only once the last one is done.
// A check stops at the first clear bit. The output register frees the input side.
// Reset: async active low; then the 32768-row bit store is cleared, one row a cycle,
//   before the first input transaction is taken.
// ----------------------------------------------------------------------------
// bloom_filter_murmur3_key160
// Bloom filter over 20-byte keys with MurmurHash3 x86_32 bit positions.
// ----------------------------------------------------------------------------
module bloom_filter_murmur3_key160 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] key_word0_i,
  input  logic [31:0] key_word1_i,
  input  logic [31:0] key_word2_i,
  input  logic [31:0] key_word3_i,
  input  logic [31:0] key_word4_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        maybe_present_o,
  output logic [31:0] inserted_total_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [20:0] cfg_data_i
);
  import bfm_pkg::*;

  bfm_cmd_t  cmd;
  bfm_stat_t stat;

  bfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .key_word0_i      (key_word0_i),
    .key_word1_i      (key_word1_i),
    .key_word2_i      (key_word2_i),
    .key_word3_i      (key_word3_i),
    .key_word4_i      (key_word4_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .maybe_present_o  (maybe_present_o),
    .inserted_total_o (inserted_total_o)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction");
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && $past(out_valid_o, 2) |-> inserted_total_o >= $past(inserted_total_o, 2))
    else $error("insert count went down");
  a_insert_not_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stat.op == OpInsert && cmd.step == StepNop && !in_stall_o
      |-> !maybe_present_o)
    else $error("insert reported present");
`endif

endmodule

[tb/sv/bloom_filter_murmur3_key160_checker.sv]
// ----------------------------------------------------------------------------
// bloom_filter_murmur3_key160_checker
// Watches the key and answer channels and the register port, keeps a shadow
// bit store, predicts each answer with MurmurHash3 and compares field by field.
// ----------------------------------------------------------------------------
module bloom_filter_murmur3_key160_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        operation_i,
  input  logic [31:0] key_word0_i,
  input  logic [31:0] key_word1_i,
  input  logic [31:0] key_word2_i,
  input  logic [31:0] key_word3_i,
  input  logic [31:0] key_word4_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        maybe_present_i,
  input  logic [31:0] inserted_total_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [20:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          answers_o,
  output int          hits_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bfm_pkg::*;

  typedef struct {
    logic        present;
    logic [31:0] total;
  } answer_t;

  bit          shadow_bits [MaxFilterBits];
  logic [31:0] shadow_inserts;
  logic [4:0]  shadow_hashes;
  logic [20:0] shadow_size;
  answer_t     answer_q [$];

  function automatic logic [31:0] rot(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] murmur20(logic [31:0] w [5], logic [31:0] seed);
    logic [31:0] h, k;
    h = seed;
    for (int b = 0; b < 5; b++) begin
      k = rot(w[b] * MmC1, 15) * MmC2;
      h = rot(h ^ k, 13) * 5 + MmE;
    end
    h ^= MmLen;
    h ^= h >> 16;
    h *= MmF1;
    h ^= h >> 13;
    h *= MmF2;
    h ^= h >> 16;
    return h;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    answer_t     a;
    logic [31:0] w [5];
    int          nh;
    longint      fb, pos;
    if (!rst_ni) begin
      foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
      shadow_inserts = '0;
      shadow_hashes  = 5'd14;
      shadow_size    = 21'd1048576;
      answer_q.delete();
      errors_o  = 0;
      answers_o = 0;
      hits_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgNumHashes) shadow_hashes = cfg_data_i[4:0];
        else shadow_size = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        answers_o++;
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected transaction", 32'd1, 32'd0);
        end else begin
          a = answer_q.pop_front();
          if (maybe_present_i !== a.present)
            report_mismatch("maybe_present", maybe_present_i, a.present);
          if (inserted_total_i !== a.total)
            report_mismatch("inserted_total", inserted_total_i, a.total);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        w = '{key_word0_i, key_word1_i, key_word2_i, key_word3_i, key_word4_i};
        nh = (shadow_hashes > MaxHashes) ? MaxHashes : shadow_hashes;
        fb = (shadow_size == 0) ? 1 : shadow_size;
        if (fb > MaxFilterBits) fb = MaxFilterBits;
        a.present = 1'b1;
        for (int i = 0; i < nh; i++) begin
          pos = longint'(murmur20(w, i)) % fb;
          if (operation_i == OpCheck) begin
            if (!shadow_bits[pos]) begin
              a.present = 1'b0;
              break;
            end
          end else begin
            shadow_bits[pos] = 1'b1;
          end
        end
        if (operation_i == OpInsert) begin
          a.present = 1'b0;
          if (shadow_inserts != 32'hffffffff) shadow_inserts++;
        end else if (a.present) begin
          hits_o++;
        end
        a.total = shadow_inserts;
        answer_q.push_back(a);
      end
    end
    pending_o = answer_q.size();
  end
endmodule

[tb/sv/bloom_filter_murmur3_key160_test.sv]
// ----------------------------------------------------------------------------
// bloom_filter_murmur3_key160_test
// Drives inserts and membership checks of 160-bit keys under several hash
// counts and filter sizes, with random idle and stall phases.
// ----------------------------------------------------------------------------
module bloom_filter_murmur3_key160_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bfm_pkg::*;

  localparam int WatchdogLimit = 200000;
  localparam int DrainCycles   = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OpInsert;
  logic [31:0] key_word0_i = '0, key_word1_i = '0, key_word2_i = '0;
  logic [31:0] key_word3_i = '0, key_word4_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        maybe_present_o;
  logic [31:0] inserted_total_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CfgNumHashes;
  logic [20:0] cfg_data_i = '0;

  int errors, pending, answers, hits;
  int send_idle_pct, stall_pct, idle_count;
  int keys_sent;
  logic [31:0] key_pool [$][5];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bloom_filter_murmur3_key160 i_dut (.*);

  bloom_filter_murmur3_key160_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i,
    .key_word0_i, .key_word1_i, .key_word2_i, .key_word3_i, .key_word4_i,
    .out_valid_i(out_valid_o), .out_stall_i, .maybe_present_i(maybe_present_o),
    .inserted_total_i(inserted_total_o), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .answers_o(answers), .hits_o(hits)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > WatchdogLimit) begin
      $display("watchdog expired with %0d answers pending", pending);
      $display("bloom_filter_murmur3_key160 test failed");
      $finish;
    end
  end

  task automatic send_key(logic op, logic [31:0] w [5]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    {key_word4_i, key_word3_i, key_word2_i, key_word1_i, key_word0_i}
      <= {w[4], w[3], w[2], w[1], w[0]};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    keys_sent++;
    if (op == OpInsert && key_pool.size() < 400) key_pool.push_back(w);
  endtask

  task automatic send_random;
    logic [31:0] w [5];
    int sel;
    sel = $urandom_range(99);
    foreach (w[i]) w[i] = $urandom();
    if (sel < 15) foreach (w[i]) w[i] = $urandom_range(1) ? 32'hffffffff : 32'h0;
    if (sel >= 50 && key_pool.size() > 0) begin
      w = key_pool[$urandom_range(key_pool.size() - 1)];
      if (sel >= 85) w[$urandom_range(4)][$urandom_range(31)] ^= 1'b1;
      send_key(OpCheck, w);
    end else begin
      send_key(logic'($urandom_range(1)), w);
    end
  endtask

  task automatic write_reg(logic idx, logic [20:0] val);
    in_valid_i <= 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_pool.delete();
  endtask

  initial begin
    logic [31:0] w [5];
    logic [4:0]  hash_set [6] = '{5'd1, 5'd0, 5'd20, 5'd31, 5'd3, 5'd7};
    logic [20:0] size_set [6] = '{21'd64, 21'd0, 21'd1, 21'h1fffff, 21'd1048576, 21'd1000};
    int idle_set [4] = '{0, 87, 0, 38};
    int stall_set [4] = '{0, 0, 87, 38};
    send_idle_pct = 0;
    stall_pct     = 0;
    keys_sent     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, both operations, repeated keys at reset config
    w = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    send_key(OpCheck, w);
    send_key(OpInsert, w);
    send_key(OpCheck, w);
    w = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
    send_key(OpInsert, w);
    send_key(OpCheck, w);
    w = '{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h1};
    send_key(OpCheck, w);
    send_key(OpInsert, w);
    send_key(OpCheck, w);
    w = '{32'h80000000, 32'h1, 32'h7fffffff, 32'hfffffffe, 32'h12345678};
    send_key(OpCheck, w);

    // zero hashes, too many hashes, zero and oversized filter, size change
    write_reg(CfgNumHashes, 21'd0);
    send_key(OpCheck, w);
    send_key(OpInsert, w);
    write_reg(CfgNumHashes, 21'd31);
    write_reg(CfgFilterBits, 21'd0);
    send_key(OpCheck, w);
    send_key(OpInsert, w);
    send_key(OpCheck, w);
    write_reg(CfgFilterBits, 21'h1fffff);
    send_key(OpCheck, w);
    send_key(OpInsert, w);
    write_reg(CfgFilterBits, 21'd16);
    send_key(OpCheck, w);

    for (int phase = 0; phase < 24; phase++) begin
      write_reg(CfgNumHashes, 21'(hash_set[phase % 6]));
      write_reg(CfgFilterBits, size_set[(phase / 4) % 6]);
      send_idle_pct = idle_set[phase % 4];
      stall_pct     = stall_set[phase % 4];
      for (int n = 0; n < 75; n++) send_random();
    end
    in_valid_i    <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;

    repeat (DrainCycles) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    $display("%0d keys sent, %0d answers checked, %0d checks found possibly present",
             keys_sent, answers, hits);
    $display("covered hash counts 0..31 and filter sizes 0..max under idle/stall mixes");
    if (errors == 0 && pending == 0) begin
      $display("bloom_filter_murmur3_key160 test passed");
    end else begin
      $display("bloom_filter_murmur3_key160 test failed");
    end
    $finish;
  end
endmodule
